// ===== src/dct_pkg.sv =====
// shared types, codes and constants of the deadline callback table
`timescale 1ns / 1ps
`default_nettype none
package dct_pkg;

  localparam int SLOTS_DEF = 16;
  localparam int MAX_RES   = 16;
  localparam int FIRE_IW   = $clog2(MAX_RES);
  localparam int FIRE_CW   = $clog2(MAX_RES + 1);

  localparam int HANDLE_W = 8;
  localparam int TIME_W   = 32;
  localparam int STATUS_W = 3;

  localparam logic [TIME_W-1:0] ALL_ONES = '1;

  typedef enum logic [1:0] {
    FN_ADD    = 2'd0,
    FN_REMOVE = 2'd1,
    FN_TICK   = 2'd2,
    FN_RSVD   = 2'd3
  } func_t;

  localparam logic [STATUS_W-1:0] STAT_OK    = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_NULL  = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_DUP   = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_EMPTY = 3'd4;

  // flags from the shared compare unit
  typedef struct packed {
    logic lt_min;
    logic lt_now;
    logic hit;
  } cmp_t;

endpackage
`default_nettype wire

// ===== src/deadline_callback_table_unit.sv =====
// top level: sequencer, fired handle queue and result register
//
//  channel | ports                                   | direction
//  in      | in_valid in_stall in_func in_handle      | item in
//          | in_delay in_now                          |
//  out     | out_valid out_stall out_fired_handle      | result out
//          | out_fired_valid out_status               |
//          | out_next_deadline out_last               |
//
// add, remove and tick scan every slot through one registered memory read port and
// one compare unit: accept, then the scan of every slot, then a commit for add, then
// one result each time the output register frees up.
// null add/remove and the unused code skip the scan and go straight to the results.
// rst_n clears all slots, the earliest deadline goes to all ones.
// in_stall is high from accept until the last result is loaded; a stalled
// result holds in the output register.
`timescale 1ns / 1ps
`default_nettype none
module deadline_callback_table_unit #(
  parameter int SLOTS = dct_pkg::SLOTS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   in_func,
  input  logic [dct_pkg::HANDLE_W-1:0] in_handle,
  input  logic [dct_pkg::TIME_W-1:0]   in_delay,
  input  logic [dct_pkg::TIME_W-1:0]   in_now,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [dct_pkg::HANDLE_W-1:0] out_fired_handle,
  output logic                         out_fired_valid,
  output logic [dct_pkg::STATUS_W-1:0] out_status,
  output logic [dct_pkg::TIME_W-1:0]   out_next_deadline,
  output logic                         out_last
);
  import dct_pkg::*;

  localparam int IW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT,
    ST_EMIT
  } state_t;

  state_t              state_r;
  func_t               func_r;
  logic [HANDLE_W-1:0] handle_r;
  logic [TIME_W-1:0]   now_r;
  logic [TIME_W-1:0]   dl_r;
  logic [TIME_W-1:0]   earliest_r;
  logic [TIME_W-1:0]   min_r;
  logic [CW-1:0]       cnt_r;
  logic [IW-1:0]       free_slot_r;
  logic                free_found_r;
  logic                dup_r;
  logic                any_r;
  logic [STATUS_W-1:0] status_r;
  logic [FIRE_CW-1:0]  fire_cnt_r;
  logic [FIRE_IW-1:0]  emit_idx_r;
  logic [HANDLE_W-1:0] fire_q [MAX_RES];

  logic                out_valid_r;
  logic [HANDLE_W-1:0] out_fired_handle_r;
  logic                out_fired_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [TIME_W-1:0]   out_next_deadline_r;
  logic                out_last_r;

  logic [IW-1:0]       rd_addr;
  logic [IW-1:0]       proc_idx;
  logic [HANDLE_W-1:0] rd_handle;
  logic [TIME_W-1:0]   rd_deadline;
  logic                rd_occ;
  logic                wr_en;
  logic                clr_en;
  logic [TIME_W-1:0]   cmp_dl;
  logic [TIME_W-1:0]   cmp_min;
  cmp_t                cmp;

  logic                proc;
  logic                hit;
  logic                fire;
  logic                drop;
  logic [TIME_W-1:0]   min_nxt;
  logic                out_free;
  logic                emit_last;

  assign rd_addr  = (cnt_r < CW'(SLOTS)) ? cnt_r[IW-1:0] : '0;
  assign proc_idx = IW'(cnt_r - CW'(1));

  dct_slot_store #(
    .SLOTS (SLOTS),
    .IW    (IW)
  ) u_store (
    .clk           (clk),
    .rst_n         (rst_n),
    .rd_addr       (rd_addr),
    .rd_handle_r   (rd_handle),
    .rd_deadline_r (rd_deadline),
    .rd_valid_r    (rd_occ),
    .wr_en         (wr_en),
    .wr_addr       (free_slot_r),
    .wr_handle     (handle_r),
    .wr_deadline   (dl_r),
    .clr_en        (clr_en),
    .clr_addr      (proc_idx)
  );

  // the commit cycle reuses the unit to fold the new deadline into the earliest one
  assign cmp_dl  = (state_r == ST_COMMIT) ? dl_r : rd_deadline;
  assign cmp_min = (state_r == ST_COMMIT) ? earliest_r : min_r;

  dct_cmp_unit u_cmp (
    .dl       (cmp_dl),
    .min_val  (cmp_min),
    .now      (now_r),
    .handle_a (rd_handle),
    .handle_b (handle_r),
    .cmp      (cmp)
  );

  always_comb begin
    proc    = (state_r == ST_SCAN) && (cnt_r != '0);
    hit     = rd_occ && cmp.hit;
    fire    = (func_r == FN_TICK) && rd_occ && cmp.lt_now &&
              (fire_cnt_r < FIRE_CW'(MAX_RES));
    drop    = fire || ((func_r == FN_REMOVE) && hit);
    min_nxt = (rd_occ && !drop && cmp.lt_min) ? rd_deadline : min_r;
    clr_en  = proc && drop;
    wr_en   = (state_r == ST_COMMIT) && !dup_r && free_found_r;
  end

  assign out_free  = !out_valid_r || !out_stall;
  assign emit_last = ({1'b0, emit_idx_r} == (fire_cnt_r - FIRE_CW'(1)));

  always_ff @(posedge clk) begin
    if (proc && fire) begin
      fire_q[fire_cnt_r[FIRE_IW-1:0]] <= rd_handle;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      earliest_r   <= ALL_ONES;
      out_valid_r  <= 1'b0;
      cnt_r        <= '0;
      fire_cnt_r   <= '0;
      emit_idx_r   <= '0;
      free_found_r <= 1'b0;
      dup_r        <= 1'b0;
      any_r        <= 1'b0;
    end else begin
      // in the emit state the result register is reloaded whenever it frees up
      if (out_valid_r && !out_stall && state_r != ST_EMIT) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            func_r       <= func_t'(in_func);
            handle_r     <= in_handle;
            now_r        <= in_now;
            dl_r         <= in_now + in_delay;
            cnt_r        <= '0;
            fire_cnt_r   <= '0;
            emit_idx_r   <= '0;
            free_found_r <= 1'b0;
            dup_r        <= 1'b0;
            any_r        <= 1'b0;
            min_r        <= ALL_ONES;
            if ((func_t'(in_func) == FN_ADD || func_t'(in_func) == FN_REMOVE) &&
                in_handle == '0) begin
              status_r <= STAT_NULL;
              state_r  <= ST_EMIT;
            end else if (func_t'(in_func) == FN_RSVD) begin
              status_r <= STAT_OK;
              state_r  <= ST_EMIT;
            end else begin
              status_r <= STAT_OK;
              state_r  <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (proc) begin
            min_r <= min_nxt;
            if (rd_occ) begin
              any_r <= 1'b1;
            end
            if (fire) begin
              fire_cnt_r <= fire_cnt_r + FIRE_CW'(1);
            end
            if (func_r == FN_ADD) begin
              if (hit) begin
                dup_r <= 1'b1;
              end
              if (!rd_occ && !free_found_r) begin
                free_found_r <= 1'b1;
                free_slot_r  <= proc_idx;
              end
            end
          end
          cnt_r <= cnt_r + CW'(1);
          if (cnt_r == CW'(SLOTS)) begin
            if (func_r == FN_ADD) begin
              state_r <= ST_COMMIT;
            end else begin
              earliest_r <= min_nxt;
              state_r    <= ST_EMIT;
            end
          end
        end
        ST_COMMIT: begin
          priority if (dup_r) begin
            status_r <= STAT_DUP;
          end else if (!free_found_r) begin
            status_r <= STAT_FULL;
          end else begin
            status_r <= STAT_OK;
            if (cmp.lt_min) begin
              earliest_r <= dl_r;
            end
          end
          state_r <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid_r         <= 1'b1;
            out_next_deadline_r <= earliest_r;
            if (func_r == FN_TICK && fire_cnt_r != '0) begin
              out_fired_handle_r <= fire_q[emit_idx_r];
              out_fired_valid_r  <= 1'b1;
              out_status_r       <= STAT_OK;
              out_last_r         <= emit_last;
              emit_idx_r         <= emit_idx_r + FIRE_IW'(1);
              if (emit_last) begin
                state_r <= ST_IDLE;
              end
            end else begin
              out_fired_handle_r <= '0;
              out_fired_valid_r  <= 1'b0;
              out_last_r         <= 1'b1;
              if (func_r == FN_TICK) begin
                out_status_r <= any_r ? STAT_OK : STAT_EMPTY;
              end else begin
                out_status_r <= status_r;
              end
              state_r <= ST_IDLE;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_stall          = (state_r != ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_fired_handle  = out_fired_handle_r;
  assign out_fired_valid   = out_fired_valid_r;
  assign out_status        = out_status_r;
  assign out_next_deadline = out_next_deadline_r;
  assign out_last          = out_last_r;

endmodule
`default_nettype wire

// ===== src/dct_cmp_unit.sv =====
// shared compare unit used once per scanned slot and once at add commit
`timescale 1ns / 1ps
`default_nettype none
module dct_cmp_unit (
  input  logic [dct_pkg::TIME_W-1:0]   dl,
  input  logic [dct_pkg::TIME_W-1:0]   min_val,
  input  logic [dct_pkg::TIME_W-1:0]   now,
  input  logic [dct_pkg::HANDLE_W-1:0] handle_a,
  input  logic [dct_pkg::HANDLE_W-1:0] handle_b,
  output dct_pkg::cmp_t                cmp
);
  import dct_pkg::*;

  assign cmp.lt_min = (dl < min_val);
  assign cmp.lt_now = (dl < now);
  assign cmp.hit    = (handle_a == handle_b);

endmodule
`default_nettype wire

// ===== src/dct_slot_store.sv =====
// slot memory for handles and deadlines with occupancy flags
`timescale 1ns / 1ps
`default_nettype none
module dct_slot_store #(
  parameter int SLOTS = dct_pkg::SLOTS_DEF,
  parameter int IW    = $clog2(SLOTS)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [IW-1:0]                rd_addr,
  output logic [dct_pkg::HANDLE_W-1:0] rd_handle_r,
  output logic [dct_pkg::TIME_W-1:0]   rd_deadline_r,
  output logic                         rd_valid_r,
  input  logic                         wr_en,
  input  logic [IW-1:0]                wr_addr,
  input  logic [dct_pkg::HANDLE_W-1:0] wr_handle,
  input  logic [dct_pkg::TIME_W-1:0]   wr_deadline,
  input  logic                         clr_en,
  input  logic [IW-1:0]                clr_addr
);
  import dct_pkg::*;

  logic [HANDLE_W-1:0] mem_handle [SLOTS];
  logic [TIME_W-1:0]   mem_deadline [SLOTS];
  logic [SLOTS-1:0]    occ_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_handle[wr_addr]   <= wr_handle;
      mem_deadline[wr_addr] <= wr_deadline;
    end
    rd_handle_r   <= mem_handle[rd_addr];
    rd_deadline_r <= mem_deadline[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r      <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      rd_valid_r <= occ_r[rd_addr];
      if (clr_en) begin
        occ_r[clr_addr] <= 1'b0;
      end
      if (wr_en) begin
        occ_r[wr_addr] <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== verif/deadline_callback_table_checker.sv =====
// checker for the deadline callback table: predicts every result and compares
`timescale 1ns / 1ps
`default_nettype none
module deadline_callback_table_checker
  import dct_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  logic [1:0]          in_func,
  input  logic [HANDLE_W-1:0] in_handle,
  input  logic [TIME_W-1:0]   in_delay,
  input  logic [TIME_W-1:0]   in_now,
  input  logic                out_valid,
  input  logic                out_stall,
  input  logic [HANDLE_W-1:0] out_fired_handle,
  input  logic                out_fired_valid,
  input  logic [STATUS_W-1:0] out_status,
  input  logic [TIME_W-1:0]   out_next_deadline,
  input  logic                out_last,
  output int                  mismatch_count,
  output int                  pending_results
);

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic                fired;
    logic [STATUS_W-1:0] status;
    logic [TIME_W-1:0]   next_deadline;
    logic                last;
  } timer_result_t;

  logic [HANDLE_W-1:0] table_handle [SLOTS_DEF];
  logic [TIME_W-1:0]   table_deadline [SLOTS_DEF];
  logic [TIME_W-1:0]   soonest_deadline;
  timer_result_t       expected_fires_q [$];

  task automatic report_mismatch(string what, logic [TIME_W-1:0] got,
                                 logic [TIME_W-1:0] want);
    $display("%0t: %s mismatch: got %0h, want %0h", $time, what, got, want);
    mismatch_count++;
  endtask

  function automatic logic [TIME_W-1:0] scan_soonest();
    logic [TIME_W-1:0] m;
    m = ALL_ONES;
    for (int i = 0; i < SLOTS_DEF; i++) begin
      if (table_handle[i] != '0 && table_deadline[i] < m) m = table_deadline[i];
    end
    return m;
  endfunction

  task automatic push_result(logic [HANDLE_W-1:0] h, logic fired,
                             logic [STATUS_W-1:0] st, logic lst);
    timer_result_t r;
    r.handle        = h;
    r.fired         = fired;
    r.status        = st;
    r.next_deadline = soonest_deadline;
    r.last          = lst;
    expected_fires_q.push_back(r);
  endtask

  task automatic predict_timer_item(func_t fn, logic [HANDLE_W-1:0] h,
                                    logic [TIME_W-1:0] dly, logic [TIME_W-1:0] now);
    int                  free_idx;
    bit                  dup;
    bit                  any_busy;
    int                  n_fired;
    logic [HANDLE_W-1:0] fired_list [MAX_RES];
    free_idx = -1;
    dup      = 1'b0;
    any_busy = 1'b0;
    n_fired  = 0;
    case (fn)
      FN_ADD: begin
        if (h == '0) begin
          push_result('0, 1'b0, STAT_NULL, 1'b1);
        end else begin
          for (int i = 0; i < SLOTS_DEF; i++) begin
            if (table_handle[i] == '0) begin
              if (free_idx < 0) free_idx = i;
            end else if (table_handle[i] == h) begin
              dup = 1'b1;
            end
          end
          if (dup) begin
            push_result('0, 1'b0, STAT_DUP, 1'b1);
          end else if (free_idx < 0) begin
            push_result('0, 1'b0, STAT_FULL, 1'b1);
          end else begin
            table_handle[free_idx]   = h;
            table_deadline[free_idx] = now + dly;
            if (table_deadline[free_idx] < soonest_deadline)
              soonest_deadline = table_deadline[free_idx];
            push_result('0, 1'b0, STAT_OK, 1'b1);
          end
        end
      end
      FN_REMOVE: begin
        if (h == '0) begin
          push_result('0, 1'b0, STAT_NULL, 1'b1);
        end else begin
          for (int i = 0; i < SLOTS_DEF; i++) begin
            if (table_handle[i] == h) table_handle[i] = '0;
          end
          soonest_deadline = scan_soonest();
          push_result('0, 1'b0, STAT_OK, 1'b1);
        end
      end
      FN_TICK: begin
        // fires in slot order, strictly-below compare against now
        for (int i = 0; i < SLOTS_DEF; i++) begin
          if (table_handle[i] != '0) begin
            any_busy = 1'b1;
            if (n_fired < MAX_RES && table_deadline[i] < now) begin
              fired_list[n_fired] = table_handle[i];
              n_fired++;
              table_handle[i] = '0;
            end
          end
        end
        soonest_deadline = scan_soonest();
        if (n_fired == 0) begin
          push_result('0, 1'b0, any_busy ? STAT_OK : STAT_EMPTY, 1'b1);
        end else begin
          for (int k = 0; k < n_fired; k++)
            push_result(fired_list[k], 1'b1, STAT_OK, k == n_fired - 1);
        end
      end
      default: begin
        push_result('0, 1'b0, STAT_OK, 1'b1);
      end
    endcase
  endtask

  task automatic check_result(logic [HANDLE_W-1:0] h, logic fired,
                              logic [STATUS_W-1:0] st, logic [TIME_W-1:0] nd,
                              logic lst);
    timer_result_t want;
    if (expected_fires_q.size() == 0) begin
      report_mismatch("unexpected result transfer, handle", h, '0);
      return;
    end
    want = expected_fires_q.pop_front();
    if (h != want.handle) report_mismatch("fired_handle", h, want.handle);
    if (fired != want.fired) report_mismatch("fired_valid", fired, want.fired);
    if (st != want.status) report_mismatch("status", st, want.status);
    if (nd != want.next_deadline) report_mismatch("next_deadline", nd, want.next_deadline);
    if (lst != want.last) report_mismatch("last", lst, want.last);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS_DEF; i++) begin
        table_handle[i]   = '0;
        table_deadline[i] = '0;
      end
      soonest_deadline = ALL_ONES;
      expected_fires_q.delete();
    end else begin
      if (in_valid && !in_stall)
        predict_timer_item(func_t'(in_func), in_handle, in_delay, in_now);
      if (out_valid && !out_stall)
        check_result(out_fired_handle, out_fired_valid, out_status, out_next_deadline,
                     out_last);
    end
    pending_results = expected_fires_q.size();
  end

endmodule
`default_nettype wire

// ===== verif/deadline_callback_table_unit_tb.sv =====
// testbench top for the deadline callback table: stimulus, flow control and verdict
`timescale 1ns / 1ps
`default_nettype none
module deadline_callback_table_unit_tb;
  import dct_pkg::*;

  localparam int QUIET_LIMIT     = 3000;
  localparam int LONG_HOLD       = 320;
  localparam int ITEMS_PER_PHASE = 76;

  logic                clk;
  logic                rst_n             = 1'b0;
  logic                in_valid          = 1'b0;
  logic                in_stall;
  logic [1:0]          in_func           = '0;
  logic [HANDLE_W-1:0] in_handle         = '0;
  logic [TIME_W-1:0]   in_delay          = '0;
  logic [TIME_W-1:0]   in_now            = '0;
  logic                out_valid;
  logic                out_stall         = 1'b0;
  logic [HANDLE_W-1:0] out_fired_handle;
  logic                out_fired_valid;
  logic [STATUS_W-1:0] out_status;
  logic [TIME_W-1:0]   out_next_deadline;
  logic                out_last;

  int                  mismatch_count;
  int                  pending_results;
  int                  send_idle_pct     = 0;
  int                  stall_pct         = 0;
  int                  hold_asked        = 0;
  int                  hold_served       = 0;
  int                  quiet_cycles      = 0;
  logic [TIME_W-1:0]   ms_clock          = '0;
  int                  idle_by_phase [4] = '{0, 46, 0, 28};
  int                  stall_by_phase [4] = '{0, 0, 46, 28};

  deadline_callback_table_unit uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_func           (in_func),
    .in_handle         (in_handle),
    .in_delay          (in_delay),
    .in_now            (in_now),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_fired_handle  (out_fired_handle),
    .out_fired_valid   (out_fired_valid),
    .out_status        (out_status),
    .out_next_deadline (out_next_deadline),
    .out_last          (out_last)
  );

  deadline_callback_table_checker table_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_func           (in_func),
    .in_handle         (in_handle),
    .in_delay          (in_delay),
    .in_now            (in_now),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_fired_handle  (out_fired_handle),
    .out_fired_valid   (out_fired_valid),
    .out_status        (out_status),
    .out_next_deadline (out_next_deadline),
    .out_last          (out_last),
    .mismatch_count    (mismatch_count),
    .pending_results   (pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // receiver: a requested long hold-off first, random stalls otherwise
  always @(posedge clk) begin
    if (hold_served < hold_asked) begin
      out_stall   <= 1'b1;
      hold_served <= hold_served + 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // watchdog on stretches with no transfer on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("deadline_callback_table_unit_tb NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_item(func_t fn, logic [HANDLE_W-1:0] h, logic [TIME_W-1:0] dly,
                           logic [TIME_W-1:0] now);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_func   <= fn;
    in_handle <= h;
    in_delay  <= dly;
    in_now    <= now;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_results != 0);
    @(posedge clk);
  endtask

  // mostly a small handle pool and a slowly advancing clock, so adds collide,
  // removes hit and ticks find due handles
  task automatic send_random_timer_item();
    int                  pick;
    logic [HANDLE_W-1:0] h;
    logic [TIME_W-1:0]   dly;
    pick = $urandom_range(99);
    if ($urandom_range(9) == 0) h = HANDLE_W'($urandom_range(255));
    else h = HANDLE_W'($urandom_range(20, 1));
    if ($urandom_range(15) == 0) dly = $urandom;
    else dly = $urandom_range(300);
    if ($urandom_range(31) == 0) ms_clock = $urandom;
    else ms_clock = ms_clock + $urandom_range(40);
    if (pick < 45) send_item(FN_ADD, h, dly, ms_clock);
    else if (pick < 65) send_item(FN_REMOVE, h, dly, ms_clock);
    else if (pick < 95) send_item(FN_TICK, h, dly, ms_clock);
    else if (pick < 97) send_item(FN_RSVD, h, dly, ms_clock);
    else send_item(pick[0] ? FN_ADD : FN_REMOVE, '0, dly, ms_clock);
  endtask

  initial begin
    int k;
    int phase;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(FN_TICK, '0, '0, '0);           // tick on an empty table
    send_item(FN_ADD, '0, '1, 32'd100);       // null add
    send_item(FN_REMOVE, '0, '0, 32'd100);    // null remove
    send_item(FN_RSVD, '1, '1, '1);
    send_item(FN_ADD, '1, '0, '1);            // deadline at the top of the range
    send_item(FN_ADD, 8'd1, '1, 32'd5);       // deadline wraps around to 4
    send_item(FN_ADD, 8'd1, 32'd9, 32'd5);    // duplicate keeps the old deadline
    send_item(FN_TICK, '0, '0, 32'd4);        // equal to now is not due yet
    send_item(FN_REMOVE, 8'd77, '0, 32'd4);   // handle not pending
    for (k = 2; k <= 15; k++) send_item(FN_ADD, 8'(k), 32'(k * 3), 32'd10);
    send_item(FN_ADD, 8'd200, 32'd1, 32'd10); // table full
    send_item(FN_TICK, '0, '0, '1);           // fires everything except the top one
    send_item(FN_REMOVE, '1, '0, '0);

    for (phase = 0; phase < 4; phase++) begin
      send_idle_pct = idle_by_phase[phase];
      stall_pct     = stall_by_phase[phase];
      for (k = 0; k < ITEMS_PER_PHASE; k++) begin
        // long receiver hold-off while items keep coming, so the input backs up
        if (phase == 0 && k == 20) hold_asked = LONG_HOLD;
        send_random_timer_item();
      end
      if (phase == 1) wait_for_drain();
    end

    wait_for_drain();
    repeat (40) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("deadline_callback_table_unit_tb OK");
    end else begin
      $display("deadline_callback_table_unit_tb NOT OK");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== files.f =====
src/dct_pkg.sv
src/dct_cmp_unit.sv
src/dct_slot_store.sv
src/deadline_callback_table_unit.sv
verif/deadline_callback_table_checker.sv
verif/deadline_callback_table_unit_tb.sv
